// ----- rtl/blrp_pkg.sv -----
// Shared widths, constants and types of the byte lane ROM pointer step block.
`timescale 1ns / 1ps

package blrp_pkg;

   localparam int ADDR_W   = 32;
   localparam int OFFSET_W = 24;
   localparam int LANES    = 4;
   localparam int LANE_W   = 2;

   // Reciprocal of three scaled by two to the RECIP3_SHIFT. It is exact for offset magnitudes
   // up to two to the 23rd.
   localparam logic [OFFSET_W-1:0] RECIP3       = 24'hAAAAAB;
   localparam int                  RECIP3_SHIFT = 25;

   localparam logic [LANES-1:0] LANE_MASK_RESET = 4'hF;

   typedef enum logic {
      STATUS_OK    = 1'b0,
      STATUS_ERROR = 1'b1
   } status_type;

   typedef struct packed {
      logic [LANES-1:0]  mask;
      logic [LANE_W-1:0] lane;
      logic [1:0]        remainder;
      logic              backward;
   } walk_req_type;

endpackage

// ----- rtl/blrp_if.sv -----
// Valid/ready channel interfaces for requests, responses and the lane mask register.
`timescale 1ns / 1ps

interface blrp_req_if;
   logic                                   valid;
   logic                                   ready;
   logic [blrp_pkg::ADDR_W-1:0]            current_address;
   logic signed [blrp_pkg::OFFSET_W-1:0]   logical_offset;

   modport source (output valid, output current_address, output logical_offset, input ready);
   modport sink (input valid, input current_address, input logical_offset, output ready);
endinterface

interface blrp_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [blrp_pkg::ADDR_W-1:0] new_address;
   logic                        status;

   modport source (output valid, output new_address, output status, input ready);
   modport sink (input valid, input new_address, input status, output ready);
endinterface

interface blrp_csr_if;
   logic                       valid;
   logic                       ready;
   logic [blrp_pkg::LANES-1:0] write_data;

   modport source (output valid, output write_data, input ready);
   modport sink (input valid, input write_data, output ready);
endinterface

// ----- rtl/blrp_lane_walk.sv -----
// Walks the leftover logical bytes across active lanes and returns the physical byte step.
`timescale 1ns / 1ps

module blrp_lane_walk (
   input  blrp_pkg::walk_req_type walk_req,
   output logic signed [3:0]      delta
);

   logic [1:0]                  left;
   logic [blrp_pkg::LANE_W-1:0] lane_cur;
   logic [1:0]                  steps;

   // Each remaining logical byte needs one more active lane; at most three other lanes exist,
   // so three physical steps always suffice.
   always_comb begin
      left     = walk_req.remainder;
      lane_cur = walk_req.lane;
      steps    = 2'd0;
      for (int i = 0; i < 3; i++) begin
         if (left != 2'd0) begin
            if (walk_req.backward) begin
               lane_cur = lane_cur - 2'd1;
            end else begin
               lane_cur = lane_cur + 2'd1;
            end
            steps = steps + 2'd1;
            if (walk_req.mask[lane_cur]) begin
               left = left - 2'd1;
            end
         end
      end
      if (walk_req.backward) begin
         delta = -$signed({2'b00, steps});
      end else begin
         delta = $signed({2'b00, steps});
      end
   end

endmodule

// ----- rtl/byte_lane_rom_pointer_step_top.sv -----
// Top level of the byte lane ROM pointer step block.
`timescale 1ns / 1ps

// A request beat carries a ROM byte address and a signed logical byte offset; the response
// beat gives the physical address of the byte that many active-lane bytes away, or status
// error with address zero when the current byte sits on a lane outside the lane mask. The
// block is a four-stage pipeline (input decode and lane count, reciprocal multiply for the
// division by the lane count, remainder and sign, lane walk and final add); one request is
// taken in every cycle while the response side keeps up. Each stage holds only while the
// stage after it is full and blocked, so bubbles close up under a stalled response. The lane
// mask register resets to all four lanes; the user must write it only while no request is in
// flight, which the block itself does not enforce. Its write channel is always ready.

module byte_lane_rom_pointer_step_top (
   input  logic              clock,
   input  logic              reset,
   blrp_req_if.sink          req_chan,
   blrp_rsp_if.source        rsp_chan,
   blrp_csr_if.sink          csr_chan
);

   localparam int AW = blrp_pkg::ADDR_W;
   localparam int OW = blrp_pkg::OFFSET_W;
   localparam int NL = blrp_pkg::LANES;
   localparam int LW = blrp_pkg::LANE_W;

   logic [NL-1:0] lane_mask_ff;

   logic en1, en2, en3, en4;
   logic v1_ff, v2_ff, v3_ff, v4_ff;

   // Stage 1.
   logic [AW-1:0] s1_addr_ff, s1_addr_in;
   logic [OW-1:0] s1_abs_ff, s1_abs_in;
   logic          s1_neg_ff, s1_neg_in;
   logic [2:0]    s1_count_ff, s1_count_in;
   logic          s1_err_ff, s1_err_in;
   logic [NL-1:0] s1_mask_ff;

   // Stage 2.
   logic [AW-1:0]   s2_addr_ff;
   logic [OW-1:0]   s2_abs_ff;
   logic            s2_neg_ff;
   logic [2:0]      s2_count_ff;
   logic            s2_err_ff;
   logic [NL-1:0]   s2_mask_ff;
   logic [OW-1:0]   s2_quot_ff, s2_quot_in;
   logic [2*OW-1:0] product;

   // Stage 3.
   logic [AW-1:0]        s3_addr_ff;
   logic                 s3_neg_ff;
   logic                 s3_err_ff;
   logic [NL-1:0]        s3_mask_ff;
   logic signed [OW:0]   s3_quot_ff, s3_quot_in;
   logic [1:0]           s3_rem_ff, s3_rem_in;
   logic [OW+1:0]        quot_times_n;
   logic [OW+1:0]        rem_diff;

   // Stage 4.
   logic [AW-1:0]             s4_addr_ff, s4_addr_in;
   logic                      s4_status_ff;
   blrp_pkg::status_type      s4_status_in;
   blrp_pkg::walk_req_type    walk_req;
   logic signed [3:0]         walk_delta;
   logic [AW-1:0]             word_step;
   logic [AW-1:0]             byte_step;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_mask_ff <= blrp_pkg::LANE_MASK_RESET;
      end else if (csr_chan.valid) begin
         lane_mask_ff <= csr_chan.write_data;
      end
   end

   assign en4 = !v4_ff || rsp_chan.ready;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_chan.ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= req_chan.valid;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
         if (en3) begin
            v3_ff <= v2_ff;
         end
         if (en4) begin
            v4_ff <= v3_ff;
         end
      end
   end

   // Stage 1: lane check, active lane count and offset magnitude.
   always_comb begin
      s1_addr_in  = req_chan.current_address;
      s1_neg_in   = req_chan.logical_offset[OW-1];
      if (s1_neg_in) begin
         s1_abs_in = ~req_chan.logical_offset + OW'(1);
      end else begin
         s1_abs_in = req_chan.logical_offset;
      end
      s1_count_in = 3'(lane_mask_ff[0]) + 3'(lane_mask_ff[1])
                  + 3'(lane_mask_ff[2]) + 3'(lane_mask_ff[3]);
      s1_err_in   = !lane_mask_ff[req_chan.current_address[LW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_addr_ff  <= s1_addr_in;
         s1_abs_ff   <= s1_abs_in;
         s1_neg_ff   <= s1_neg_in;
         s1_count_ff <= s1_count_in;
         s1_err_ff   <= s1_err_in;
         s1_mask_ff  <= lane_mask_ff;
      end
   end

   // Stage 2: magnitude divided by the lane count.
   assign product = (2*OW)'(s1_abs_ff) * (2*OW)'(blrp_pkg::RECIP3);

   always_comb begin
      case (s1_count_ff)
         3'd1:    s2_quot_in = s1_abs_ff;
         3'd2:    s2_quot_in = s1_abs_ff >> 1;
         3'd3:    s2_quot_in = OW'(product >> blrp_pkg::RECIP3_SHIFT);
         default: s2_quot_in = s1_abs_ff >> 2;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         s2_addr_ff  <= s1_addr_ff;
         s2_abs_ff   <= s1_abs_ff;
         s2_neg_ff   <= s1_neg_ff;
         s2_count_ff <= s1_count_ff;
         s2_err_ff   <= s1_err_ff;
         s2_mask_ff  <= s1_mask_ff;
         s2_quot_ff  <= s2_quot_in;
      end
   end

   // Stage 3: remainder magnitude and signed quotient.
   always_comb begin
      case (s2_count_ff)
         3'd1:    quot_times_n = (OW+2)'(s2_quot_ff);
         3'd2:    quot_times_n = (OW+2)'(s2_quot_ff) << 1;
         3'd3:    quot_times_n = (OW+2)'(s2_quot_ff) + ((OW+2)'(s2_quot_ff) << 1);
         default: quot_times_n = (OW+2)'(s2_quot_ff) << 2;
      endcase
      rem_diff  = (OW+2)'(s2_abs_ff) - quot_times_n;
      s3_rem_in = rem_diff[1:0];
      if (s2_neg_ff) begin
         s3_quot_in = -$signed({1'b0, s2_quot_ff});
      end else begin
         s3_quot_in = $signed({1'b0, s2_quot_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         s3_addr_ff <= s2_addr_ff;
         s3_neg_ff  <= s2_neg_ff;
         s3_err_ff  <= s2_err_ff;
         s3_mask_ff <= s2_mask_ff;
         s3_quot_ff <= s3_quot_in;
         s3_rem_ff  <= s3_rem_in;
      end
   end

   // Stage 4: lane walk of the remainder and the final address.
   assign walk_req.mask      = s3_mask_ff;
   assign walk_req.lane      = s3_addr_ff[LW-1:0];
   assign walk_req.remainder = s3_rem_ff;
   assign walk_req.backward  = s3_neg_ff;

   blrp_lane_walk u_walk (
      .walk_req (walk_req),
      .delta    (walk_delta)
   );

   assign word_step = {{(AW-OW-3){s3_quot_ff[OW]}}, s3_quot_ff, 2'b00};
   assign byte_step = {{(AW-4){walk_delta[3]}}, walk_delta};

   always_comb begin
      if (s3_err_ff) begin
         s4_addr_in   = '0;
         s4_status_in = blrp_pkg::STATUS_ERROR;
      end else begin
         s4_addr_in   = s3_addr_ff + word_step + byte_step;
         s4_status_in = blrp_pkg::STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         s4_addr_ff   <= s4_addr_in;
         s4_status_ff <= s4_status_in;
      end
   end

   assign rsp_chan.valid       = v4_ff;
   assign rsp_chan.new_address = s4_addr_ff;
   assign rsp_chan.status      = s4_status_ff;

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the byte lane ROM pointer step block.
`timescale 1ns / 1ps

module testbench;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int ITEMS_PER_PHASE = 47;

   typedef struct packed {
      logic [blrp_pkg::ADDR_W-1:0] new_address;
      blrp_pkg::status_type        status;
   } pointer_result_type;

   class lane_step_scoreboard;
      logic [blrp_pkg::LANES-1:0] lane_mask;
      pointer_result_type         expected_steps[$];
      int                         mismatches;

      function new();
         lane_mask   = blrp_pkg::LANE_MASK_RESET;
         mismatches  = 0;
      endfunction

      function void set_mask(logic [blrp_pkg::LANES-1:0] m);
         lane_mask = m;
      endfunction

      function pointer_result_type target_address(logic [blrp_pkg::ADDR_W-1:0] cur,
                                                  logic signed [blrp_pkg::OFFSET_W-1:0] offset);
         pointer_result_type          r;
         int                          lanes;
         int                          off;
         int                          step;
         int                          rem;
         int                          guard;
         logic [blrp_pkg::LANE_W-1:0] lane;
         lanes         = $countones(lane_mask);
         lane          = cur[blrp_pkg::LANE_W-1:0];
         r.new_address = '0;
         r.status      = blrp_pkg::STATUS_ERROR;
         if (lanes == 0 || !lane_mask[lane]) return r;
         off  = {{(32-blrp_pkg::OFFSET_W){offset[blrp_pkg::OFFSET_W-1]}}, offset};
         step = (off / lanes) * 4;
         rem  = off % lanes;
         for (guard = 0; rem < 0 && guard < 16; guard++) begin
            step--;
            lane = lane - 2'd1;
            if (lane_mask[lane]) rem++;
         end
         for (guard = 0; rem > 0 && guard < 16; guard++) begin
            step++;
            lane = lane + 2'd1;
            if (lane_mask[lane]) rem--;
         end
         r.new_address = cur + blrp_pkg::ADDR_W'(step);
         r.status      = blrp_pkg::STATUS_OK;
         return r;
      endfunction

      function void note_request(logic [blrp_pkg::ADDR_W-1:0] cur,
                                 logic signed [blrp_pkg::OFFSET_W-1:0] offset);
         expected_steps.push_back(target_address(cur, offset));
      endfunction

      function void report_mismatch(string what);
         mismatches++;
         if (mismatches <= 10) $display("%t: %s", $realtime, what);
      endfunction

      function void check_result(logic [blrp_pkg::ADDR_W-1:0] addr, logic status);
         pointer_result_type want;
         if (expected_steps.size() == 0) begin
            report_mismatch($sformatf("response beat with nothing outstanding: addr %h status %0d",
                                      addr, status));
            return;
         end
         want = expected_steps.pop_front();
         if (want.new_address !== addr)
            report_mismatch($sformatf("new_address expected %h actual %h",
                                      want.new_address, addr));
         if (want.status !== blrp_pkg::status_type'(status))
            report_mismatch($sformatf("status expected %0d actual %0d", want.status, status));
      endfunction

      function int pending();
         return expected_steps.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   quiet_phase;
   int   idle_cycles;
   int   stall_left;

   lane_step_scoreboard sb;

   blrp_req_if req_if ();
   blrp_rsp_if rsp_if ();
   blrp_csr_if csr_if ();

   byte_lane_rom_pointer_step_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (6) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
   end

   function automatic int idle_gap();
      int r;
      if (quiet_phase) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      else if (r < 85) return $urandom_range(1, 3);
      else if (r < 97) return $urandom_range(4, 12);
      else return $urandom_range(20, 60);
   endfunction

   initial rsp_if.ready = 1'b0;

   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_if.ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_if.ready <= 1'b1;
         if ($urandom_range(0, 9) < 3) stall_left = idle_gap();
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready)
            sb.note_request(req_if.current_address, req_if.logical_offset);
         if (rsp_if.valid && rsp_if.ready)
            sb.check_result(rsp_if.new_address, rsp_if.status);
         if (csr_if.valid && csr_if.ready)
            sb.set_mask(csr_if.write_data);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_request(input logic [blrp_pkg::ADDR_W-1:0] addr,
                               input logic signed [blrp_pkg::OFFSET_W-1:0] offset);
      int gap;
      gap = idle_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_if.valid           <= 1'b0;
         req_if.current_address <= $urandom;
         req_if.logical_offset  <= blrp_pkg::OFFSET_W'($urandom);
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_if.valid           <= 1'b1;
      req_if.current_address <= addr;
      req_if.logical_offset  <= offset;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic drain_requests();
      @(negedge clock) req_if.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic program_lane_mask(input logic [blrp_pkg::LANES-1:0] m);
      drain_requests();
      @(negedge clock);
      csr_if.valid      <= 1'b1;
      csr_if.write_data <= m;
      do @(posedge clock); while (!csr_if.ready);
      @(negedge clock) csr_if.valid <= 1'b0;
   endtask

   function automatic logic [blrp_pkg::ADDR_W-1:0] pick_address(
      logic [blrp_pkg::LANES-1:0] m);
      logic [blrp_pkg::ADDR_W-1:0] a;
      logic [blrp_pkg::LANE_W-1:0] ln;
      int                          r;
      a = $urandom;
      r = $urandom_range(0, 9);
      if (r == 0) a[blrp_pkg::ADDR_W-1:8] = '1;
      else if (r == 1) a[blrp_pkg::ADDR_W-1:8] = '0;
      if (m != '0 && $urandom_range(0, 9) != 0) begin
         do ln = blrp_pkg::LANE_W'($urandom_range(0, 3)); while (!m[ln]);
         a[blrp_pkg::LANE_W-1:0] = ln;
      end
      return a;
   endfunction

   function automatic logic signed [blrp_pkg::OFFSET_W-1:0] pick_offset();
      int r;
      r = $urandom_range(0, 9);
      if (r < 5) return blrp_pkg::OFFSET_W'(int'($urandom_range(0, 24)) - 12);
      else if (r < 7) return blrp_pkg::OFFSET_W'($urandom);
      else if (r < 9) return blrp_pkg::OFFSET_W'(int'($urandom_range(0, 4095)) - 2048);
      case ($urandom_range(0, 3))
         0: return 24'h7FFFFF;
         1: return 24'h800000;
         2: return 24'h7FFFFE;
         default: return 24'h800001;
      endcase
   endfunction

   logic [blrp_pkg::LANES-1:0] mask_order[16];
   logic [blrp_pkg::LANES-1:0] swap_mask;
   int                         pick;

   initial begin
      sb                     = new();
      quiet_phase            = 1'b0;
      idle_cycles            = 0;
      req_if.valid           = 1'b0;
      req_if.current_address = '0;
      req_if.logical_offset  = '0;
      csr_if.valid           = 1'b0;
      csr_if.write_data      = '0;
      wait (!reset);

      send_request(32'h0000_0000, 24'sd0);
      send_request(32'hFFFF_FFFF, 24'sd1);
      send_request(32'h0000_0000, -24'sd1);
      send_request(32'h1234_5678, 24'h7FFFFF);
      send_request(32'h1234_5679, 24'h800000);
      send_request(32'hFFFF_FFFC, 24'h7FFFFF);
      send_request(32'h0000_0003, 24'h800000);

      program_lane_mask(4'b1001);
      send_request(32'h0000_1000, -24'sd1);
      send_request(32'h0000_1003, 24'sd1);
      send_request(32'h0000_1001, 24'sd5);
      send_request(32'h0000_1002, 24'sd0);
      send_request(32'h0000_0000, 24'h800000);
      send_request(32'h0000_0003, 24'h7FFFFF);

      program_lane_mask(4'b0111);
      send_request(32'h0000_0100, 24'h7FFFFF);
      send_request(32'h0000_0101, 24'h800000);
      send_request(32'h0000_0100, -24'sd1);
      send_request(32'h0000_0103, 24'sd0);
      send_request(32'h0000_0102, 24'sd2);
      send_request(32'h0000_0000, -24'sd7);

      program_lane_mask(4'b0000);
      send_request(32'h0000_0000, 24'sd0);
      send_request(32'hFFFF_FFFF, 24'h7FFFFF);

      program_lane_mask(4'b0100);
      send_request(32'h0000_0002, -24'sd1);
      send_request(32'h0000_0002, 24'sd3);

      for (int i = 0; i < 16; i++) mask_order[i] = blrp_pkg::LANES'(i);
      for (int i = 15; i > 0; i--) begin
         pick              = $urandom_range(0, i);
         swap_mask         = mask_order[i];
         mask_order[i]     = mask_order[pick];
         mask_order[pick]  = swap_mask;
      end

      foreach (mask_order[p]) begin
         program_lane_mask(mask_order[p]);
         quiet_phase = ($urandom_range(0, 3) == 0);
         repeat (ITEMS_PER_PHASE) send_request(pick_address(mask_order[p]), pick_offset());
         quiet_phase = 1'b0;
      end

      drain_requests();
      repeat (16) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
